/* rtl/core/lifo_stack_dup_swap_rotate_defines.svh */
// Assertion macros shared by the stack modules
`ifndef LIFO_STACK_DUP_SWAP_ROTATE_DEFINES_SVH
`define LIFO_STACK_DUP_SWAP_ROTATE_DEFINES_SVH
`ifndef SYNTH
`define LSDSR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lifo stack check failed");
`define LSDSR_ASSERT_IMP(lbl, clk, rst_n, en, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (prop)) \
        else $error("lifo stack check failed");
`else
`define LSDSR_ASSERT(lbl, clk, rst_n, prop)
`define LSDSR_ASSERT_IMP(lbl, clk, rst_n, en, prop)
`endif
`endif

/* rtl/core/lsdsr_pkg.sv */
package lsdsr_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int ROT_W  = 9;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH = 3'd0,
        REQ_POP  = 3'd1,
        REQ_DUP  = 3'd2,
        REQ_EXCH = 3'd3,
        REQ_LROT = 3'd4,
        REQ_RROT = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEG,
        ST_RD,
        ST_WLO,
        ST_WHI,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic look;
        logic accept;
        logic exec;
        logic seg_load;
        logic seg_next;
        logic swap_rd;
        logic wr_lo;
        logic wr_hi;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic swap;
        logic rot;
        logic seg_live;
        logic last_seg;
        logic more;
    } t_stat;

endpackage

/* rtl/core/lsdsr_dpath.sv */
`include "lifo_stack_dup_swap_rotate_defines.svh"

module lsdsr_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsdsr_pkg::t_cmd             i_cmd,
    output lsdsr_pkg::t_stat            o_stat,
    input  logic [lsdsr_pkg::KIND_W-1:0] i_req_type,
    input  logic [lsdsr_pkg::DATA_W-1:0] i_push_value,
    input  logic [lsdsr_pkg::ROT_W-1:0]  i_rotate_count,
    output logic [lsdsr_pkg::DATA_W-1:0] o_top_value,
    output logic                        o_top_valid,
    output logic                        o_error,
    output logic [lsdsr_pkg::CNT_W-1:0]  o_length_after
);
    import lsdsr_pkg::*;

    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_ALL  = 2'd2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_word;
    logic [ROT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  n_len;
    logic [ADDR_W-1:0] r_lo;
    logic [ADDR_W-1:0] r_hi;
    logic [ADDR_W-1:0] r_shift;
    logic [1:0]        r_seg;
    logic [DATA_W-1:0] r_res_top;
    logic              r_res_valid;
    logic              r_res_err;
    logic [DATA_W-1:0] r_out_top;
    logic              r_out_valid_top;
    logic              r_out_err;
    logic [CNT_W-1:0]  r_out_len;

    logic              len_zero;
    logic              len_full;
    logic              len_lt2;
    logic [ADDR_W-1:0] top_idx;
    logic [ADDR_W-1:0] sec_idx;
    logic [CNT_W-1:0]  rot_n;
    logic [CNT_W-1:0]  rot_diff;
    logic              n_err;
    logic              is_swap;
    logic              is_rot;
    logic [ADDR_W-1:0] n_shift;
    logic [ADDR_W-1:0] seg_lo;
    logic [ADDR_W-1:0] seg_hi;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] ra_addr;
    logic [ADDR_W-1:0] rb_addr;

    assign len_zero = (r_len == '0);
    assign len_full = (r_len == CNT_W'(DEPTH));
    assign len_lt2  = (r_len < CNT_W'(2));
    assign top_idx  = r_len[ADDR_W-1:0] - ADDR_W'(1);
    assign sec_idx  = r_len[ADDR_W-1:0] - ADDR_W'(2);
    assign rot_n    = CNT_W'(r_n);
    assign rot_diff = r_len - rot_n;

    // decode the held request against the current length
    always_comb begin
        n_err   = 1'b0;
        is_swap = 1'b0;
        is_rot  = 1'b0;
        n_shift = rot_n[ADDR_W-1:0];
        case (r_kind)
            REQ_PUSH: n_err = len_full;
            REQ_POP:  n_err = len_zero;
            REQ_DUP:  n_err = len_zero || len_full;
            REQ_EXCH: begin
                n_err   = len_lt2;
                is_swap = !len_lt2;
            end
            REQ_LROT: begin
                n_err   = rot_n > r_len;
                is_rot  = !(rot_n > r_len) && (rot_n != '0) && (rot_n != r_len);
                n_shift = rot_diff[ADDR_W-1:0];
            end
            REQ_RROT: begin
                n_err  = rot_n > r_len;
                is_rot = !(rot_n > r_len) && (rot_n != '0) && (rot_n != r_len);
            end
            default: n_err = 1'b1;
        endcase
    end

    // a rotate is three reversals: below the shift point, above it, then all
    assign seg_lo = (r_seg == SEG_HIGH) ? r_shift : '0;
    assign seg_hi = (r_seg == SEG_LOW) ? (r_shift - ADDR_W'(1)) : top_idx;

    assign o_stat.swap     = is_swap;
    assign o_stat.rot      = is_rot;
    assign o_stat.seg_live = seg_lo < seg_hi;
    assign o_stat.last_seg = (r_seg == SEG_ALL);
    assign o_stat.more     = (r_lo + ADDR_W'(1)) < (r_hi - ADDR_W'(1));

    always_comb begin
        n_len = r_len;
        if (i_cmd.exec && !n_err) begin
            case (r_kind)
                REQ_PUSH, REQ_DUP: n_len = r_len + CNT_W'(1);
                REQ_POP:           n_len = r_len - CNT_W'(1);
                default:           n_len = r_len;
            endcase
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_lo;
        wdata = r_rd_a;
        if (i_cmd.exec && !n_err && (r_kind == REQ_PUSH || r_kind == REQ_DUP)) begin
            we    = 1'b1;
            waddr = r_len[ADDR_W-1:0];
            wdata = (r_kind == REQ_PUSH) ? r_word : r_rd_a;
        end else if (i_cmd.wr_lo) begin
            we    = 1'b1;
            waddr = r_lo;
            wdata = r_rd_a;
        end else if (i_cmd.wr_hi) begin
            we    = 1'b1;
            waddr = r_hi;
            wdata = r_rd_b;
        end
    end

    // port a follows the upper pointer, port b the lower one
    assign re      = i_cmd.look || i_cmd.swap_rd;
    assign ra_addr = i_cmd.look ? top_idx : r_hi;
    assign rb_addr = i_cmd.look ? sec_idx : r_lo;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_a <= r_mem[ra_addr];
            r_rd_b <= r_mem[rb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_req_type;
            r_word <= i_push_value;
            r_n    <= i_rotate_count;
        end
        if (i_cmd.exec) begin
            r_seg       <= is_swap ? SEG_ALL : SEG_LOW;
            r_shift     <= n_shift;
            r_lo        <= sec_idx;
            r_hi        <= top_idx;
            r_res_top   <= len_zero ? '0 : r_rd_a;
            r_res_valid <= !len_zero;
            r_res_err   <= n_err;
        end
        if (i_cmd.seg_load) begin
            r_lo <= seg_lo;
            r_hi <= seg_hi;
        end
        if (i_cmd.seg_next) begin
            r_seg <= r_seg + 2'd1;
        end
        // close in on the middle after each exchange of a pair
        if (i_cmd.wr_hi) begin
            r_lo <= r_lo + ADDR_W'(1);
            r_hi <= r_hi - ADDR_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_top       <= r_res_top;
            r_out_valid_top <= r_res_valid;
            r_out_err       <= r_res_err;
            r_out_len       <= r_len;
        end
    end

    assign o_top_value    = r_out_top;
    assign o_top_valid    = r_out_valid_top;
    assign o_error        = r_out_err;
    assign o_length_after = r_out_len;

    `LSDSR_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= CNT_W'(DEPTH))
    `LSDSR_ASSERT(a_refused_holds, i_clk, i_rst_n, (i_cmd.exec && n_err) |=> $stable(r_len))
    `LSDSR_ASSERT_IMP(a_pair_ordered, i_clk, i_rst_n, i_cmd.swap_rd, r_lo < r_hi)

endmodule

/* rtl/core/lsdsr_ctrl.sv */
`include "lifo_stack_dup_swap_rotate_defines.svh"

module lsdsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  lsdsr_pkg::t_stat i_stat,
    output lsdsr_pkg::t_cmd  o_cmd
);
    import lsdsr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                cmd.look = 1'b1;
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (i_stat.swap) begin
                    n_state = ST_WLO;
                end else if (i_stat.rot) begin
                    n_state = ST_SEG;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_SEG: begin
                cmd.seg_load = 1'b1;
                if (i_stat.seg_live) begin
                    n_state = ST_RD;
                end else if (i_stat.last_seg) begin
                    n_state = ST_RESULT;
                end else begin
                    cmd.seg_next = 1'b1;
                end
            end
            ST_RD: begin
                cmd.swap_rd = 1'b1;
                n_state     = ST_WLO;
            end
            ST_WLO: begin
                cmd.wr_lo = 1'b1;
                n_state   = ST_WHI;
            end
            ST_WHI: begin
                cmd.wr_hi = 1'b1;
                if (i_stat.more) begin
                    n_state = ST_RD;
                end else if (i_stat.last_seg) begin
                    n_state = ST_RESULT;
                end else begin
                    cmd.seg_next = 1'b1;
                    n_state      = ST_SEG;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `LSDSR_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !r_out_valid || !i_stall)
    `LSDSR_ASSERT_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(cmd.out_load))

endmodule

/* rtl/core/lifo_stack_dup_swap_rotate.sv */
// Bounded stack of 32-bit words: push, pop, duplicate, exchange and rotates.
// Input channel: i_valid with i_req_type, i_push_value, i_rotate_count;
// an item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid with o_top_value, o_top_valid, o_error,
// o_length_after; an item leaves at an edge with o_valid high and i_stall low.
// Push, pop, duplicate and refused requests pass from accept through an execute
// state to a result state, which loads o_valid; an exchange adds two writes.
// A rotate of a stack of length L reverses two parts and then the whole
// through the single write port of the entry memory, a read and two writes
// for each pair. o_stall is high while an item is being worked on.
// A result waits in the output register while i_stall is high; the next item
// is still taken and worked on, and only its own result waits for the register.
// Synchronous active-low reset empties the stack; stored words are not cleared
// and no clearing pass is needed, since no entry at or above the length is used.
module lifo_stack_dup_swap_rotate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lsdsr_pkg::KIND_W-1:0] i_req_type,
    input  logic [lsdsr_pkg::DATA_W-1:0] i_push_value,
    input  logic [lsdsr_pkg::ROT_W-1:0]  i_rotate_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lsdsr_pkg::DATA_W-1:0] o_top_value,
    output logic                        o_top_valid,
    output logic                        o_error,
    output logic [lsdsr_pkg::CNT_W-1:0]  o_length_after
);
    import lsdsr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lsdsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lsdsr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .i_rotate_count (i_rotate_count),
        .o_top_value    (o_top_value),
        .o_top_valid    (o_top_valid),
        .o_error        (o_error),
        .o_length_after (o_length_after)
    );

endmodule

/* tb/lifo_stack_dup_swap_rotate_tb.sv */
module lifo_stack_dup_swap_rotate_tb;
    import lsdsr_pkg::*;

    localparam logic [KIND_W-1:0] REQ_UNDEF_LO = 3'd6;
    localparam logic [KIND_W-1:0] REQ_UNDEF_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned QUIET_LO    = 420;
    localparam int unsigned QUIET_HI    = 580;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned TOTAL_REQS  = 860;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] word;
        logic [ROT_W-1:0]  count;
        logic              drain_first;
    } stack_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] top;
        logic              top_ok;
        logic              err;
        logic [CNT_W-1:0]  len;
    } stack_reply_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [KIND_W-1:0]   i_req_type = '0;
    logic [DATA_W-1:0]   i_push_value = '0;
    logic [ROT_W-1:0]    i_rotate_count = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DATA_W-1:0]   o_top_value;
    logic                o_top_valid;
    logic                o_error;
    logic [CNT_W-1:0]    o_length_after;

    stack_req_t   pending_reqs [$];
    stack_reply_t due_replies [$];
    stack_req_t   next_req;

    // shadow of the stack, entry 0 at the bottom
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_len = 0;

    int unsigned gen_len = 0;
    int unsigned n_sent = 0;
    int unsigned n_got = 0;
    int unsigned n_bad = 0;
    int unsigned n_refused = 0;
    int unsigned n_rotated = 0;
    int unsigned peak_len = 0;
    int unsigned n_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    lifo_stack_dup_swap_rotate uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .i_rotate_count (i_rotate_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_top_value    (o_top_value),
        .o_top_valid    (o_top_valid),
        .o_error        (o_error),
        .o_length_after (o_length_after)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit roll_idle(int unsigned n);
        return !(n >= QUIET_LO && n < QUIET_HI) && ($urandom_range(0, 99) < 10);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom();
    endfunction

    task automatic predict_stack_op(input logic [KIND_W-1:0] kind,
                                    input logic [DATA_W-1:0] word,
                                    input logic [ROT_W-1:0] count);
        stack_reply_t      r;
        logic [DATA_W-1:0] moved [DEPTH];
        int unsigned       len;
        int unsigned       shift;
        int unsigned       src;
        len = shadow_len;
        r.top = (len != 0) ? shadow_words[len-1] : '0;
        r.top_ok = (len != 0);
        r.err = 1'b0;
        case (kind)
            REQ_PUSH: begin
                if (len >= DEPTH) begin
                    r.err = 1'b1;
                end else begin
                    shadow_words[len] = word;
                    shadow_len = len + 1;
                end
            end
            REQ_POP: begin
                if (len == 0) r.err = 1'b1;
                else shadow_len = len - 1;
            end
            REQ_DUP: begin
                if (len == 0 || len >= DEPTH) begin
                    r.err = 1'b1;
                end else begin
                    shadow_words[len] = r.top;
                    shadow_len = len + 1;
                end
            end
            REQ_EXCH: begin
                if (len < 2) begin
                    r.err = 1'b1;
                end else begin
                    shadow_words[len-1] = shadow_words[len-2];
                    shadow_words[len-2] = r.top;
                end
            end
            REQ_LROT, REQ_RROT: begin
                if (count > len) begin
                    r.err = 1'b1;
                end else if (count != 0 && count != len) begin
                    // new entry i comes from old entry (i + shift) mod len
                    shift = (kind == REQ_LROT) ? len - count : count;
                    for (int unsigned i = 0; i < len; i++) begin
                        src = i + shift;
                        if (src >= len) src -= len;
                        moved[i] = shadow_words[src];
                    end
                    for (int unsigned i = 0; i < len; i++) shadow_words[i] = moved[i];
                    n_rotated++;
                end
            end
            default: r.err = 1'b1;
        endcase
        r.len = shadow_len[CNT_W-1:0];
        if (r.err) n_refused++;
        if (shadow_len > peak_len) peak_len = shadow_len;
        due_replies.push_back(r);
    endtask

    task automatic check_reply();
        stack_reply_t e;
        n_got++;
        if (due_replies.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("result %0d arrived with nothing expected:", n_got,
                         " top=%h ok=%0b err=%0b len=%0d",
                         o_top_value, o_top_valid, o_error, o_length_after);
        end else begin
            e = due_replies.pop_front();
            if (o_top_value !== e.top || o_top_valid !== e.top_ok || o_error !== e.err
                    || o_length_after !== e.len) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d mismatch: exp top=%h ok=%0b err=%0b len=%0d,",
                             n_got, e.top, e.top_ok, e.err, e.len,
                             " got top=%h ok=%0b err=%0b len=%0d",
                             o_top_value, o_top_valid, o_error, o_length_after);
            end
        end
    endtask

    task automatic add_req(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word,
                           input logic [ROT_W-1:0] count, input logic drain_first);
        stack_req_t q;
        q.kind = kind;
        q.word = word;
        q.count = count;
        q.drain_first = drain_first;
        pending_reqs.push_back(q);
        case (kind)
            REQ_PUSH: if (gen_len < DEPTH) gen_len++;
            REQ_POP:  if (gen_len > 0) gen_len--;
            REQ_DUP:  if (gen_len > 0 && gen_len < DEPTH) gen_len++;
            default: ;
        endcase
    endtask

    // mostly legal operations on a shallow stack, with some noise
    task automatic add_mix_req();
        int unsigned roll;
        logic [ROT_W-1:0] cnt;
        roll = $urandom_range(0, 99);
        if (roll < 30 && gen_len >= 24) roll = 40;
        cnt = ROT_W'($urandom_range(0, gen_len));
        if (roll < 30)      add_req(REQ_PUSH, rand_word(), ROT_W'($urandom()), 1'b0);
        else if (roll < 55) add_req(REQ_POP, $urandom(), ROT_W'($urandom()), 1'b0);
        else if (roll < 63) add_req(REQ_DUP, $urandom(), ROT_W'($urandom()), 1'b0);
        else if (roll < 73) add_req(REQ_EXCH, $urandom(), ROT_W'($urandom()), 1'b0);
        else if (roll < 83) add_req(REQ_LROT, $urandom(), cnt, 1'b0);
        else if (roll < 93) add_req(REQ_RROT, $urandom(), cnt, 1'b0);
        else if (roll < 97) add_req($urandom_range(0, 1) ? REQ_UNDEF_HI : REQ_UNDEF_LO,
                                    $urandom(), ROT_W'($urandom()), 1'b0);
        else add_req($urandom_range(0, 1) ? REQ_LROT : REQ_RROT, $urandom(),
                     ROT_W'($urandom_range(0, (1 << ROT_W) - 1)), 1'b0);
    endtask

    // sender: present queued items, hold a stalled one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_stack_op(i_req_type, i_push_value, i_rotate_count);
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() == 0 || roll_idle(n_sent)
                        || (pending_reqs[0].drain_first && due_replies.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    next_req = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_req_type <= next_req.kind;
                    i_push_value <= next_req.word;
                    i_rotate_count <= next_req.count;
                end
            end
        end
    end

    // receiver: check results, stall at random and once for a long stretch
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) check_reply();
            if (!hold_done && n_got >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) hold_left--;
            i_stall <= (hold_left != 0) || roll_idle(n_got);
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", n_cycles,
                     due_replies.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // requests on the empty stack, unknown kinds, then small-stack edge cases
        add_req(REQ_POP, 32'h0, 9'h0, 1'b0);
        add_req(REQ_DUP, 32'h0, 9'h0, 1'b0);
        add_req(REQ_EXCH, 32'h0, 9'h0, 1'b0);
        add_req(REQ_LROT, 32'h0, 9'd0, 1'b0);
        add_req(REQ_RROT, 32'h0, 9'd1, 1'b0);
        add_req(REQ_UNDEF_LO, 32'h0, 9'h0, 1'b0);
        add_req(REQ_UNDEF_HI, 32'hffff_ffff, 9'h1ff, 1'b0);
        add_req(REQ_PUSH, 32'h0000_0000, 9'h0, 1'b0);
        add_req(REQ_EXCH, 32'h0, 9'h0, 1'b0);
        add_req(REQ_PUSH, 32'hffff_ffff, 9'h1ff, 1'b0);
        add_req(REQ_EXCH, 32'h0, 9'h0, 1'b0);
        add_req(REQ_DUP, 32'h0, 9'h0, 1'b0);
        add_req(REQ_PUSH, 32'ha5a5_5a5a, 9'h0, 1'b0);
        add_req(REQ_PUSH, 32'h5a5a_a5a5, 9'h0, 1'b0);
        add_req(REQ_LROT, 32'h0, 9'd1, 1'b0);
        add_req(REQ_RROT, 32'h0, 9'd2, 1'b0);
        add_req(REQ_LROT, 32'h0, 9'd5, 1'b0);
        add_req(REQ_RROT, 32'h0, 9'd0, 1'b0);
        add_req(REQ_RROT, 32'h0, 9'd6, 1'b0);
        add_req(REQ_LROT, 32'h0, 9'd511, 1'b0);
        add_req(REQ_RROT, 32'h0, 9'd256, 1'b0);
        add_req(REQ_POP, 32'h0, 9'h0, 1'b0);
        add_req(REQ_LROT, 32'h0, 9'd3, 1'b0);
        add_req(REQ_POP, 32'h0, 9'h0, 1'b0);

        repeat (200) add_mix_req();

        // fill to the top after a full drain, probe the full stack, then unwind
        add_req(REQ_PUSH, rand_word(), ROT_W'($urandom()), 1'b1);
        while (gen_len < DEPTH) add_req(REQ_PUSH, rand_word(), ROT_W'($urandom()), 1'b0);
        add_req(REQ_PUSH, rand_word(), ROT_W'($urandom()), 1'b0);
        add_req(REQ_DUP, $urandom(), ROT_W'($urandom()), 1'b0);
        add_req(REQ_EXCH, $urandom(), ROT_W'($urandom()), 1'b0);
        add_req(REQ_LROT, $urandom(), ROT_W'(DEPTH), 1'b0);
        add_req(REQ_RROT, $urandom(), ROT_W'(DEPTH), 1'b0);
        add_req(REQ_LROT, $urandom(), ROT_W'($urandom_range(1, DEPTH - 1)), 1'b0);
        add_req(REQ_RROT, $urandom(), ROT_W'($urandom_range(1, DEPTH - 1)), 1'b0);
        add_req(REQ_LROT, $urandom(), ROT_W'(DEPTH + 1), 1'b0);
        add_req(REQ_RROT, $urandom(), 9'h1ff, 1'b0);
        add_req(REQ_POP, $urandom(), ROT_W'($urandom()), 1'b0);
        add_req(REQ_DUP, $urandom(), ROT_W'($urandom()), 1'b0);
        while (gen_len > 8) begin
            if ($urandom_range(0, 99) < 75)
                add_req(REQ_POP, $urandom(), ROT_W'($urandom()), 1'b0);
            else add_mix_req();
        end

        add_req(REQ_POP, $urandom(), ROT_W'($urandom()), 1'b1);
        while (pending_reqs.size() < TOTAL_REQS) add_mix_req();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_valid || due_replies.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d requests, %0d refused, %0d rotations with movement, peak depth %0d",
                 n_sent, n_refused, n_rotated, peak_len);
        $display("%0d results checked, %0d mismatched", n_got, n_bad);
        if (n_bad == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lsdsr_pkg.sv
rtl/core/lsdsr_dpath.sv
rtl/core/lsdsr_ctrl.sv
rtl/core/lifo_stack_dup_swap_rotate.sv
tb/lifo_stack_dup_swap_rotate_tb.sv
